// ===== rtl/gpfd_pkg.sv =====
// Shared types, constants and helpers for the gamepad poll frame decoder.
`default_nettype none

package gpfd_pkg;

    localparam int FRAME_BYTES_DEF = 9;
    localparam int BUTTON_COUNT    = 16;
    localparam int HELD_FIRST      = 3;
    localparam int HELD_DEPTH      = 6;
    localparam int STICK_COUNT     = 4;
    localparam int STICK_W         = 10;

    localparam logic [1:0] ST_UP       = 2'd0;
    localparam logic [1:0] ST_DOWN     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_PRESSED  = 2'd3;

    // Completed frame handed from the byte tracker to the decoder.
    typedef struct packed {
        logic                        fire;
        logic [BUTTON_COUNT-1:0]     raw;
        logic [BUTTON_COUNT-1:0]     prev;
        logic [STICK_COUNT-1:0][7:0] stick_bytes;
    } t_frame;

    // raw and prev are active low.
    function automatic logic [1:0] button_state(input logic raw_bit, input logic prev_bit);
        logic now_down;
        now_down = ~raw_bit;
        if (now_down) begin
            return prev_bit ? ST_PRESSED : ST_DOWN;
        end
        return prev_bit ? ST_UP : ST_RELEASED;
    endfunction

    // (b - 0x80) * 2, optionally negated.
    function automatic logic signed [STICK_W-1:0] stick_value(input logic [7:0] b,
                                                              input logic negate);
        logic signed [STICK_W-1:0] v;
        v = {~b[7], ~b[7], b[6:0], 1'b0};
        return negate ? -v : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gamepad_poll_frame_decoder_unit.sv =====
// Top level of the gamepad poll frame decoder.
// Takes one response byte per cycle. A result word is produced only for the last
// byte of a frame (position FRAME_BYTES-1); it is held in the result register from
// the cycle after that byte is accepted until taken. Input bytes are stalled only
// while that register is full and the output side stalls. Bytes after the last one
// of a frame are taken and ignored until the next frame_start; a frame_start in the
// middle of a frame drops the partial frame. The button word of the first frame
// after reset is compared against all zeros, so buttons that are up read released.
`default_nettype none

module gamepad_poll_frame_decoder_unit import gpfd_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic                        i_frame_start,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [2*BUTTON_COUNT-1:0]        o_button_states,
    output logic [BUTTON_COUNT-1:0]          o_event_mask,
    output logic signed [STICK_W-1:0]        o_right_x,
    output logic signed [STICK_W-1:0]        o_right_y,
    output logic signed [STICK_W-1:0]        o_left_x,
    output logic signed [STICK_W-1:0]        o_left_y
);

    t_frame w_frame;
    logic   w_accept;

    assign o_stall  = o_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    gpfd_frame_track #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_frame       (w_frame)
    );

    gpfd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (w_frame),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_button_states (o_button_states),
        .o_event_mask    (o_event_mask),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_left_x        (o_left_x),
        .o_left_y        (o_left_y)
    );

endmodule

`default_nettype wire

// ===== rtl/gpfd_frame_track.sv =====
// Byte position counter, held frame bytes and previous button word.
`default_nettype none

module gpfd_frame_track import gpfd_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_frame_start,
    output t_frame          o_frame
);

    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam logic [PW-1:0] POS_IDLE = PW'(FRAME_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(FRAME_BYTES - 1);
    localparam bit LAST_IN_STORE = (FRAME_BYTES - 1) < (HELD_FIRST + HELD_DEPTH);

    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           n_pos;
    logic [BUTTON_COUNT-1:0] r_prev;
    logic [7:0]              r_held [HELD_DEPTH];
    logic [PW-1:0]           w_pos;
    logic                    w_active;
    logic                    w_fire;

    assign w_pos    = i_frame_start ? '0 : r_pos;
    assign w_active = i_accept && (w_pos != POS_IDLE);
    assign w_fire   = w_active && (w_pos == POS_LAST);
    assign n_pos    = w_active ? w_pos + 1'b1 : w_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= '0;
        end else begin
            if (i_accept) begin
                r_pos <= n_pos;
            end
            if (w_fire) begin
                r_prev <= o_frame.raw;
            end
        end
    end

    for (genvar k = 0; k < HELD_DEPTH; k++) begin : g_held
        always_ff @(posedge i_clk) begin
            if (w_active && (w_pos == PW'(HELD_FIRST + k))) begin
                r_held[k] <= i_rx_byte;
            end
        end
    end

    always_comb begin
        o_frame.fire           = w_fire;
        o_frame.raw            = {r_held[1], r_held[0]};
        o_frame.prev           = r_prev;
        o_frame.stick_bytes[0] = r_held[2];
        o_frame.stick_bytes[1] = r_held[3];
        o_frame.stick_bytes[2] = r_held[4];
        o_frame.stick_bytes[3] = LAST_IN_STORE ? i_rx_byte : r_held[5];
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_IDLE)
        else $error("byte position beyond frame");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_pos == POS_IDLE)
        else $error("position not idle after last byte");

    a_prev_follows_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_prev == $past(o_frame.raw))
        else $error("previous button word not kept");

endmodule

`default_nettype wire

// ===== rtl/gpfd_decode.sv =====
// Button state and stick decode into the result register.
`default_nettype none

module gpfd_decode import gpfd_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_frame                      i_frame,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic [2*BUTTON_COUNT-1:0]        o_button_states,
    output logic [BUTTON_COUNT-1:0]          o_event_mask,
    output logic signed [STICK_W-1:0]        o_right_x,
    output logic signed [STICK_W-1:0]        o_right_y,
    output logic signed [STICK_W-1:0]        o_left_x,
    output logic signed [STICK_W-1:0]        o_left_y
);

    logic                      r_valid;
    logic [2*BUTTON_COUNT-1:0] r_states;
    logic [BUTTON_COUNT-1:0]   r_mask;
    logic signed [STICK_W-1:0] r_stick [STICK_COUNT];
    logic [2*BUTTON_COUNT-1:0] n_states;
    logic [BUTTON_COUNT-1:0]   n_mask;

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_states[2*i +: 2] = button_state(i_frame.raw[i], i_frame.prev[i]);
            n_mask[i]          = n_states[2*i +: 2] != ST_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_frame.fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.fire) begin
            r_states <= n_states;
            r_mask   <= n_mask;
            for (int s = 0; s < STICK_COUNT; s++) begin
                r_stick[s] <= stick_value(i_frame.stick_bytes[s], s[0]);
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_button_states = r_states;
    assign o_event_mask    = r_mask;
    assign o_right_x       = r_stick[0];
    assign o_right_y       = r_stick[1];
    assign o_left_x        = r_stick[2];
    assign o_left_y        = r_stick[3];

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.fire |-> !(r_valid && i_stall))
        else $error("result overwritten while stalled");

    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.fire |=> r_valid)
        else $error("result not presented after last byte");

    a_mask_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_mask[0] == (r_states[1:0] != ST_UP))
                 && (r_mask[BUTTON_COUNT-1] == (r_states[2*BUTTON_COUNT-1 -: 2] != ST_UP)))
        else $error("event mask disagrees with button states");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for gamepad_poll_frame_decoder_unit: directed table, random poll frames, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gpfd_pkg::*;

    localparam int STICK_CENTER  = 'h80;
    localparam int RANDOM_BYTES  = 500;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [2*BUTTON_COUNT-1:0] states;
        logic [BUTTON_COUNT-1:0]   mask;
        logic signed [STICK_W-1:0] rx;
        logic signed [STICK_W-1:0] ry;
        logic signed [STICK_W-1:0] lx;
        logic signed [STICK_W-1:0] ly;
    } t_frame_report;

    typedef struct packed {
        logic [7:0]    rxb;
        logic          fs;
        logic          typed;
        t_frame_report want;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_rx_byte;
    logic                      i_frame_start;
    logic                      o_valid;
    logic                      i_stall;
    logic [2*BUTTON_COUNT-1:0] o_button_states;
    logic [BUTTON_COUNT-1:0]   o_event_mask;
    logic signed [STICK_W-1:0] o_right_x;
    logic signed [STICK_W-1:0] o_right_y;
    logic signed [STICK_W-1:0] o_left_x;
    logic signed [STICK_W-1:0] o_left_y;

    // first frame: no frame_start, all buttons up against a zero word, stick extremes;
    // trailing bytes ignored; partial frame dropped by a new frame_start;
    // then all buttons down, sticks centered
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1,
          '{32'hAAAA_AAAA, 16'hFFFF, -10'sd256, 10'sd256, 10'sd254, -10'sd254}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1,
          '{32'hFFFF_FFFF, 16'hFFFF, 10'sd0, 10'sd0, 10'sd0, 10'sd0}}
    };

    // decoder state
    int unsigned       frame_pos;
    logic [15:0]       last_raw;
    logic [7:0]        held [HELD_FIRST:HELD_FIRST+HELD_DEPTH-1];

    t_frame_report     reports_due [$];
    int                fail_count;
    int                results_seen;
    int                useful_bytes;

    gamepad_poll_frame_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_button_states (o_button_states),
        .o_event_mask    (o_event_mask),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_left_x        (o_left_x),
        .o_left_y        (o_left_y)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic signed [STICK_W-1:0] stick_of(input logic [7:0] b,
                                                           input logic neg);
        int v;
        v = (int'(b) - STICK_CENTER) * 2;
        if (neg) begin
            v = -v;
        end
        return v[STICK_W-1:0];
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fs, output logic used,
                               output logic emits, output t_frame_report rep);
        logic [15:0] raw;
        logic        down;
        logic        same;
        int          i;
        used  = 1'b0;
        emits = 1'b0;
        rep   = '0;
        if (fs) begin
            frame_pos = 0;
        end
        if (frame_pos >= FRAME_BYTES_DEF) begin
            return;
        end
        used = 1'b1;
        if (frame_pos >= HELD_FIRST && frame_pos < HELD_FIRST + HELD_DEPTH) begin
            held[frame_pos] = b;
        end
        frame_pos++;
        if (frame_pos != FRAME_BYTES_DEF) begin
            return;
        end
        raw = {held[HELD_FIRST+1], held[HELD_FIRST]};
        for (i = 0; i < BUTTON_COUNT; i++) begin
            down = ~raw[i];
            same = (down == last_raw[i]);
            rep.states[2*i +: 2] = {same, down};
            rep.mask[i] = down | same;
        end
        last_raw = raw;
        rep.rx = stick_of(held[5], 1'b0);
        rep.ry = stick_of(held[6], 1'b1);
        rep.lx = stick_of(held[7], 1'b0);
        rep.ly = stick_of(held[8], 1'b1);
        emits = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fs, input logic typed,
                             input t_frame_report want);
        logic          used;
        logic          emits;
        t_frame_report rep;
        int            r;
        int            gap;
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        decode_byte(b, fs, used, emits, rep);
        if (emits) begin
            reports_due.push_back(typed ? want : rep);
        end
        if (used) begin
            useful_bytes++;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reports_due.size() == 0) begin
                $error("result word with none expected: button_states %h", o_button_states);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("button_states", longint'(want.states),
                            longint'(o_button_states));
                check_field("event_mask", longint'(want.mask), longint'(o_event_mask));
                check_field("right_x", longint'(want.rx), longint'(o_right_x));
                check_field("right_y", longint'(want.ry), longint'(o_right_y));
                check_field("left_x", longint'(want.lx), longint'(o_left_x));
                check_field("left_y", longint'(want.ly), longint'(o_left_y));
            end
            results_seen++;
        end
    end

    // output side: random stalls, quiet stretches, one long hold-off
    initial begin
        bit held_off;
        int mode;
        held_off = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            if (!held_off && results_seen >= 6) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (mode < 4) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end else if (mode < 8) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0]  fb [9];
        logic        fsb [9];
        logic [15:0] raw;
        int          len;
        int          kind;
        int          j;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_rx_byte     <= 8'h00;
        i_frame_start <= 1'b0;
        frame_pos     = 0;
        last_raw      = '0;
        fail_count    = 0;
        results_seen  = 0;
        raw           = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].rxb, directed_rows[r].fs, directed_rows[r].typed,
                      directed_rows[r].want);
        end

        useful_bytes = 0;
        while (useful_bytes < RANDOM_BYTES) begin
            case ($urandom_range(0, 3))
                0: raw = raw;
                1: raw = raw ^ (16'h1 << $urandom_range(0, 15));
                default: raw = 16'($urandom_range(0, 16'hFFFF));
            endcase
            for (j = 0; j < 9; j++) begin
                fb[j]  = 8'($urandom_range(0, 255));
                fsb[j] = 1'b0;
            end
            fb[3] = raw[7:0];
            fb[4] = raw[15:8];
            for (j = 5; j < 9; j++) begin
                case ($urandom_range(0, 7))
                    0: fb[j] = 8'h00;
                    1: fb[j] = 8'hFF;
                    2: fb[j] = 8'h80;
                    3: fb[j] = 8'h7F;
                    default: fb[j] = fb[j];
                endcase
            end
            fsb[0] = 1'b1;
            len = 9;
            kind = $urandom_range(0, 19);
            if (kind == 15 || kind == 16) begin
                len = $urandom_range(1, 8);
            end else if (kind == 17) begin
                fsb[0] = 1'b0;
                len = $urandom_range(1, 4);
            end else if (kind == 18) begin
                fsb[0] = 1'b0;
            end else if (kind == 19) begin
                fsb[$urandom_range(1, 8)] = 1'b1;
            end
            for (j = 0; j < len; j++) begin
                send_byte(fb[j], fsb[j], 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (reports_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[gamepad_poll_frame_decoder_unit] OK");
        end else begin
            $display("[gamepad_poll_frame_decoder_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[gamepad_poll_frame_decoder_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gpfd_pkg.sv
rtl/gpfd_frame_track.sv
rtl/gpfd_decode.sv
rtl/gamepad_poll_frame_decoder_unit.sv
dv/tb_top.sv
